>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They are clocked on clk and are disabled
// while rst_n is low. All of them compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge.
`define BCLE_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define BCLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define BCLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCLE_ASSERT(lbl, expr, msg)
`define BCLE_ASSERT_IMP(lbl, ante, cons, msg)
`define BCLE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/bcle_pkg.sv
// ----------------------------------------------------------------------------
// bcle_pkg
// Sizes, codes and item types of the banked compacting list engine.
// ----------------------------------------------------------------------------
package bcle_pkg;

    // Geometry of the list bank.
    localparam int ROOMS          = 10;
    localparam int LAYERS         = 8;
    localparam int CAPACITY       = 16;
    localparam int CLEARED_LAYERS = 6;

    // Field widths.
    localparam int ACTION_W = 3;
    localparam int ROOM_W   = 4;
    localparam int LAYER_W  = 3;
    localparam int ID_W     = 10;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 5;
    localparam int MASK_W   = 8;

    // Derived storage sizes.
    localparam int NUM_LISTS   = ROOMS * LAYERS;
    localparam int NUM_ENTRIES = NUM_LISTS * CAPACITY;
    localparam int LIST_W      = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int ENT_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int POS_W       = $clog2(CAPACITY);
    localparam int LEN_W       = $clog2(CAPACITY + 1);
    localparam int CNT_W       = LEN_W + 1;
    localparam int CMP_W       = (LEN_W > IDX_W) ? LEN_W : IDX_W;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_APPEND     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_ALL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ROOM_W-1:0]   room;
        logic [LAYER_W-1:0]  layer;
        logic [ID_W-1:0]     object_id;
        logic [IDX_W-1:0]    entry_index;
    } bcle_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LENGTH_W-1:0] length_after;
        logic [ID_W-1:0]     entry_value;
        logic [MASK_W-1:0]   removed_mask;
    } bcle_rsp_t;

endpackage

>>> hw/rtl/banked_compacting_list_engine.sv
// ----------------------------------------------------------------------------
// banked_compacting_list_engine
// Ordered id lists, one per room and layer, with append, remove with
// compaction, remove from every layer of a room, clear of the lower
// layers of a room and indexed read.
// The engine works on one item at a time and answers every item with exactly
// one result. Entries live in a single-port-read, single-port-write memory of
// ROOMS*LAYERS*CAPACITY ids, and list lengths in a second memory of
// ROOMS*LAYERS words guarded by one valid bit per list, so reset takes effect
// at once and no clearing pass is needed. The entry memory port examines or
// moves one id per cycle, and that sets the rate. An item for a room that
// does not exist, or an append, remove or read for a layer that does not
// exist, goes from the idle state straight to the push state. Remove scans
// the list for the id and, where it finds it, moves every later id down one
// place; remove-from-all-layers does this for each layer of the room in
// turn. A new item is accepted in the cycle after the result is loaded,
// even while that result still waits on a stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module banked_compacting_list_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  bcle_pkg::bcle_cmd_t   cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output bcle_pkg::bcle_rsp_t   rsp
);
    import bcle_pkg::*;

    // Sequencer states.
    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STATE_W-1:0] ST_LEN_RD   = 4'd1;
    localparam logic [STATE_W-1:0] ST_DISPATCH = 4'd2;
    localparam logic [STATE_W-1:0] ST_RD_DATA  = 4'd3;
    localparam logic [STATE_W-1:0] ST_SRCH     = 4'd4;
    localparam logic [STATE_W-1:0] ST_SHIFT    = 4'd5;
    localparam logic [STATE_W-1:0] ST_NEXT     = 4'd6;
    localparam logic [STATE_W-1:0] ST_CLEAR    = 4'd7;
    localparam logic [STATE_W-1:0] ST_FIN_RD   = 4'd8;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT = 4'd9;
    localparam logic [STATE_W-1:0] ST_PUSH     = 4'd10;

    // Index of the list for a room and layer, used only with both in range.
    function automatic logic [LIST_W-1:0] list_index(input logic [ROOM_W-1:0]  r,
                                                     input logic [LAYER_W-1:0] l);
        list_index = LIST_W'(int'(r) * LAYERS + int'(l));
    endfunction

    // Entry memory address of a position within a list.
    function automatic logic [ENT_W-1:0] entry_addr(input logic [LIST_W-1:0] lst,
                                                    input logic [POS_W-1:0]  pos);
        entry_addr = ENT_W'(int'(lst) * CAPACITY + int'(pos));
    endfunction

    function automatic logic room_in_range(input logic [ROOM_W-1:0] r);
        room_in_range = int'(r) < ROOMS;
    endfunction

    function automatic logic layer_in_range(input logic [LAYER_W-1:0] l);
        layer_in_range = int'(l) < LAYERS;
    endfunction

    // Sequencer and item registers.
    logic [STATE_W-1:0] state_reg, state_next;
    bcle_cmd_t          item_reg, item_next;
    bcle_rsp_t          res_reg, res_next;
    logic [LAYER_W-1:0] lyr_reg, lyr_next;
    logic [LIST_W-1:0]  list_reg, list_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    // Result register facing the output channel.
    logic      rsp_valid_reg;
    bcle_rsp_t rsp_reg;

    // Storage. A length whose valid bit is clear reads as zero.
    logic [ID_W-1:0]      ent_mem [NUM_ENTRIES];
    logic [LEN_W-1:0]     len_mem [NUM_LISTS];
    logic [NUM_LISTS-1:0] len_vld_reg;
    logic [ID_W-1:0]      ent_rd_reg;
    logic [LEN_W-1:0]     len_rd_reg;
    logic                 vld_rd_reg;

    // Memory port controls.
    logic              ent_we, ent_re;
    logic [ENT_W-1:0]  ent_wa, ent_ra;
    logic [ID_W-1:0]   ent_wd;
    logic              len_we, len_re;
    logic [LIST_W-1:0] len_wa, len_ra;
    logic [LEN_W-1:0]  len_wd;
    logic              clr_room;

    logic [LAYER_W-1:0] cur_layer;
    logic [LIST_W-1:0]  cur_list;
    logic [LIST_W-1:0]  item_list;
    logic [LEN_W-1:0]   len_eff;
    logic [CNT_W-1:0]   pos_p1;
    logic [CNT_W-1:0]   pos_p2;
    logic               rsp_free;
    logic               push;

    // The block takes an item only from the idle state.
    assign cmd_stall = (state_reg != ST_IDLE);

    // Remove-from-all-layers steps through the layers; every other action
    // works on the layer that the item names.
    assign cur_layer = (item_reg.action == ACT_REMOVE_ALL) ? lyr_reg : item_reg.layer;
    assign cur_list  = list_index(item_reg.room, cur_layer);
    assign item_list = list_index(item_reg.room, item_reg.layer);
    assign len_eff   = vld_rd_reg ? len_rd_reg : '0;
    assign pos_p1    = CNT_W'(pos_reg) + CNT_W'(1);
    assign pos_p2    = CNT_W'(pos_reg) + CNT_W'(2);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign push      = (state_reg == ST_PUSH) && rsp_free;

    // Sequencer. Memory reads and writes are spread over states so that the
    // same address is never written and read in one cycle: a length is only
    // read in ST_LEN_RD and ST_FIN_RD and only written elsewhere, and during
    // compaction the write to position p goes along with the read of p + 2.
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        lyr_next   = lyr_reg;
        list_next  = list_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        ent_we     = 1'b0;
        ent_wa     = entry_addr(list_reg, pos_reg);
        ent_wd     = ent_rd_reg;
        ent_re     = 1'b0;
        ent_ra     = entry_addr(list_reg, '0);
        len_we     = 1'b0;
        len_wa     = list_reg;
        len_wd     = len_reg - LEN_W'(1);
        len_re     = 1'b0;
        len_ra     = cur_list;
        clr_room   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next = cmd;
                    res_next  = '0;
                    lyr_next  = '0;
                    if (!room_in_range(cmd.room))
                    begin
                        res_next.status = STS_RANGE;
                        state_next      = ST_PUSH;
                    end
                    else
                    begin
                        unique case (cmd.action) inside
                            ACT_REMOVE_ALL:
                            begin
                                state_next = ST_LEN_RD;
                            end
                            ACT_CLEAR:
                            begin
                                state_next = ST_CLEAR;
                            end
                            ACT_APPEND, ACT_REMOVE, ACT_READ:
                            begin
                                if (layer_in_range(cmd.layer))
                                begin
                                    state_next = ST_LEN_RD;
                                end
                                else
                                begin
                                    res_next.status = STS_RANGE;
                                    state_next      = ST_PUSH;
                                end
                            end
                            default:
                            begin
                                state_next = ST_FIN_RD;
                            end
                        endcase
                    end
                end
            end

            ST_LEN_RD:
            begin
                len_re     = 1'b1;
                len_ra     = cur_list;
                list_next  = cur_list;
                state_next = ST_DISPATCH;
            end

            ST_DISPATCH:
            begin
                len_next = len_eff;
                pos_next = '0;
                unique case (item_reg.action) inside
                    ACT_APPEND:
                    begin
                        if (len_eff >= LEN_W'(CAPACITY))
                        begin
                            res_next.status = STS_FULL;
                        end
                        else
                        begin
                            ent_we = 1'b1;
                            ent_wa = entry_addr(list_reg, POS_W'(len_eff));
                            ent_wd = item_reg.object_id;
                            len_we = 1'b1;
                            len_wa = list_reg;
                            len_wd = len_eff + LEN_W'(1);
                        end
                        state_next = ST_FIN_RD;
                    end
                    ACT_READ:
                    begin
                        if (CMP_W'(item_reg.entry_index) >= CMP_W'(len_eff))
                        begin
                            res_next.status = STS_RANGE;
                            state_next      = ST_FIN_RD;
                        end
                        else
                        begin
                            ent_re     = 1'b1;
                            ent_ra     = entry_addr(list_reg, POS_W'(item_reg.entry_index));
                            state_next = ST_RD_DATA;
                        end
                    end
                    ACT_REMOVE, ACT_REMOVE_ALL:
                    begin
                        if (len_eff == '0)
                        begin
                            state_next = ST_NEXT;
                        end
                        else
                        begin
                            ent_re     = 1'b1;
                            ent_ra     = entry_addr(list_reg, '0);
                            state_next = ST_SRCH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN_RD;
                    end
                endcase
            end

            ST_RD_DATA:
            begin
                res_next.entry_value = ent_rd_reg;
                state_next           = ST_FIN_RD;
            end

            ST_SRCH:
            begin
                // ent_rd_reg holds the id at pos_reg.
                if (ent_rd_reg == item_reg.object_id)
                begin
                    if (pos_p1 < CNT_W'(len_reg))
                    begin
                        ent_re     = 1'b1;
                        ent_ra     = entry_addr(list_reg, POS_W'(pos_p1));
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        // Match in the last slot: nothing to move.
                        len_we                          = 1'b1;
                        res_next.removed_mask[cur_layer] = 1'b1;
                        state_next                      = ST_NEXT;
                    end
                end
                else if (pos_p1 < CNT_W'(len_reg))
                begin
                    pos_next = POS_W'(pos_p1);
                    ent_re   = 1'b1;
                    ent_ra   = entry_addr(list_reg, POS_W'(pos_p1));
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end

            ST_SHIFT:
            begin
                // ent_rd_reg holds the id at pos_reg + 1; move it down one place.
                ent_we   = 1'b1;
                ent_wa   = entry_addr(list_reg, pos_reg);
                ent_wd   = ent_rd_reg;
                pos_next = POS_W'(pos_p1);
                if (pos_p2 < CNT_W'(len_reg))
                begin
                    ent_re = 1'b1;
                    ent_ra = entry_addr(list_reg, POS_W'(pos_p2));
                end
                else
                begin
                    len_we                          = 1'b1;
                    res_next.removed_mask[cur_layer] = 1'b1;
                    state_next                      = ST_NEXT;
                end
            end

            ST_NEXT:
            begin
                if ((item_reg.action == ACT_REMOVE_ALL) && (int'(lyr_reg) != LAYERS - 1))
                begin
                    lyr_next   = lyr_reg + LAYER_W'(1);
                    state_next = ST_LEN_RD;
                end
                else
                begin
                    if (res_reg.removed_mask == '0)
                    begin
                        res_next.status = STS_NOT_FOUND;
                    end
                    state_next = ST_FIN_RD;
                end
            end

            ST_CLEAR:
            begin
                clr_room   = 1'b1;
                state_next = ST_FIN_RD;
            end

            ST_FIN_RD:
            begin
                // The reported length is that of the named list after the
                // action, or zero when the layer does not exist.
                if (layer_in_range(item_reg.layer))
                begin
                    len_re     = 1'b1;
                    len_ra     = item_list;
                    state_next = ST_FIN_WAIT;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end

            ST_FIN_WAIT:
            begin
                res_next.length_after = LENGTH_W'(len_eff);
                state_next            = ST_PUSH;
            end

            ST_PUSH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Item and working registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        lyr_reg  <= lyr_next;
        list_reg <= list_next;
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        if (push)
        begin
            rsp_reg <= res_reg;
        end
    end

    // Length valid bits. A write marks a list valid; clear-room drops the
    // lower layers of the room back to their reset length of zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg <= '0;
        end
        else
        begin
            if (len_we)
            begin
                len_vld_reg[len_wa] <= 1'b1;
            end
            if (clr_room)
            begin
                for (int l = 0; l < LAYERS; l++)
                begin
                    if (l < CLEARED_LAYERS)
                    begin
                        len_vld_reg[list_index(item_reg.room, LAYER_W'(l))] <= 1'b0;
                    end
                end
            end
        end
    end

    // Length memory.
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        if (len_re)
        begin
            len_rd_reg <= len_mem[len_ra];
            vld_rd_reg <= len_vld_reg[len_ra];
        end
    end

    // Entry memory.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re)
        begin
            ent_rd_reg <= ent_mem[ent_ra];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks.
    `BCLE_ASSERT_NXT(a_accept_leaves_idle, cmd_valid && !cmd_stall, state_reg != ST_IDLE, "accepted item did not start the sequencer")
    `BCLE_ASSERT(a_len_no_rw_clash, !(len_we && len_re && (len_wa == len_ra)), "length memory read and written at one address")
    `BCLE_ASSERT(a_ent_no_rw_clash, !(ent_we && ent_re && (ent_wa == ent_ra)), "entry memory read and written at one address")
    `BCLE_ASSERT_IMP(a_len_bound, len_we, int'(len_wd) <= CAPACITY, "list length written beyond capacity")
    `BCLE_ASSERT_IMP(a_rsp_from_push, $rose(rsp_valid_reg), $past(state_reg) == ST_PUSH, "result raised outside the push state")

endmodule

>>> dv/banked_compacting_list_engine_checker.sv
// ----------------------------------------------------------------------------
// banked_compacting_list_engine_checker
// Passive checker for the list engine. It keeps its own copy of every list,
// works out the result of each accepted command item and compares each
// accepted result item, field by field, with the oldest result still owed.
// ----------------------------------------------------------------------------
module banked_compacting_list_engine_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  bcle_pkg::bcle_cmd_t cmd,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  bcle_pkg::bcle_rsp_t rsp,
    output int                  mismatches,
    output int                  results_owed
);
    import bcle_pkg::*;

    logic [ID_W-1:0] list_ids [NUM_LISTS][CAPACITY];
    int              list_len [NUM_LISTS];
    bcle_rsp_t       owed_results [$];

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Deletes the first entry equal to id and closes the gap.
    function automatic bit drop_first_match(int list, logic [ID_W-1:0] id);
        int pos;
        pos = 0;
        while (pos < list_len[list] && list_ids[list][pos] != id)
            pos++;
        if (pos >= list_len[list])
            return 1'b0;
        while (pos + 1 < list_len[list])
        begin
            list_ids[list][pos] = list_ids[list][pos + 1];
            pos++;
        end
        list_ids[list][list_len[list] - 1] = '0;
        list_len[list]--;
        return 1'b1;
    endfunction

    // Applies one command to the list copy and returns the result it causes.
    function automatic bcle_rsp_t apply_list_command(bcle_cmd_t c);
        bcle_rsp_t r;
        int        list;
        int        len;
        r    = '0;
        list = int'(c.room) * LAYERS + int'(c.layer);
        if (int'(c.room) >= ROOMS)
        begin
            r.status = STS_RANGE;
        end
        else if (c.action == ACT_REMOVE_ALL || c.action == ACT_CLEAR)
        begin
            for (int l = 0; l < LAYERS; l++)
            begin
                if (c.action == ACT_REMOVE_ALL)
                begin
                    if (drop_first_match(int'(c.room) * LAYERS + l, c.object_id))
                        r.removed_mask[l] = 1'b1;
                end
                else if (l < CLEARED_LAYERS)
                begin
                    for (int p = 0; p < CAPACITY; p++)
                        list_ids[int'(c.room) * LAYERS + l][p] = '0;
                    list_len[int'(c.room) * LAYERS + l] = 0;
                end
            end
            if (c.action == ACT_REMOVE_ALL && r.removed_mask == '0)
                r.status = STS_NOT_FOUND;
            if (int'(c.layer) < LAYERS)
                r.length_after = LENGTH_W'(list_len[list]);
        end
        else if (int'(c.layer) >= LAYERS)
        begin
            r.status = (c.action <= ACT_READ) ? STS_RANGE : STS_OK;
        end
        else
        begin
            len = list_len[list];
            case (c.action)
                ACT_APPEND:
                begin
                    if (len >= CAPACITY)
                    begin
                        r.status = STS_FULL;
                    end
                    else
                    begin
                        list_ids[list][len] = c.object_id;
                        list_len[list]      = len + 1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (drop_first_match(list, c.object_id))
                        r.removed_mask[c.layer] = 1'b1;
                    else
                        r.status = STS_NOT_FOUND;
                end
                ACT_READ:
                begin
                    if (int'(c.entry_index) >= len)
                        r.status = STS_RANGE;
                    else
                        r.entry_value = list_ids[list][c.entry_index];
                end
                default:
                begin
                end
            endcase
            r.length_after = LENGTH_W'(list_len[list]);
        end
        return r;
    endfunction

    task automatic check_result(bcle_rsp_t got);
        bcle_rsp_t want;
        if (owed_results.size() == 0)
        begin
            report_mismatch($sformatf("result %p arrived with nothing owed", got));
            return;
        end
        want = owed_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      got.status, want.status));
        if (got.length_after !== want.length_after)
            report_mismatch($sformatf("length_after got %0d want %0d",
                                      got.length_after, want.length_after));
        if (got.entry_value !== want.entry_value)
            report_mismatch($sformatf("entry_value got %0d want %0d",
                                      got.entry_value, want.entry_value));
        if (got.removed_mask !== want.removed_mask)
            report_mismatch($sformatf("removed_mask got %b want %b",
                                      got.removed_mask, want.removed_mask));
    endtask

    // A result is checked before the command of the same edge is predicted:
    // the engine may take the next command at the edge its result leaves.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                list_len[i] = 0;
                for (int p = 0; p < CAPACITY; p++)
                    list_ids[i][p] = '0;
            end
            owed_results.delete();
            mismatches   = 0;
            results_owed = 0;
        end
        else
        begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
                check_result(rsp);
            if (cmd_valid === 1'b1 && cmd_stall === 1'b0)
                owed_results.push_back(apply_list_command(cmd));
            results_owed = owed_results.size();
        end
    end

endmodule

>>> dv/banked_compacting_list_engine_tb.sv
// ----------------------------------------------------------------------------
// banked_compacting_list_engine_tb
// Regression for the banked compacting list engine. A directed opening walks
// the corner cases, then random command items, focused on a few lists at a
// time, fill, drain and clear the lists while both channels idle at random.
// ----------------------------------------------------------------------------
module banked_compacting_list_engine_tb;
    import bcle_pkg::*;

    // Action codes the engine does not define; they must change nothing.
    localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    // Counted command items in the random part. Items to rooms that do not
    // exist and items with unused action codes are not counted.
    localparam int RANDOM_ITEMS = 1700;

    // The random part favours one room and two of its layers at a time so
    // that lists get full; the focus moves on after this many counted items.
    localparam int FOCUS_SPAN = 200;

    // Window of counted items in which neither side idles nor stalls.
    localparam int CALM_FIRST = 900;
    localparam int CALM_LAST  = 1200;

    // Percentage of cycles in which either side idles.
    localparam int IDLE_PCT = 34;

    // The slowest item is remove from all layers with every list full. The
    // drain waits longer than that item takes after the last result, and the
    // watchdog allows many times as long with no item moving on either side.
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 3000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    bcle_cmd_t cmd;
    logic      rsp_valid;
    logic      rsp_stall;
    bcle_rsp_t rsp;

    int mismatch_count;
    int results_owed;
    bit calm;

    banked_compacting_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // The checker sees both channels exactly as the engine does and reports
    // its mismatch count and the number of results still owed.
    banked_compacting_list_engine_checker list_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .mismatches   (mismatch_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiving side stalls at random, except inside the calm window.
    // Like every other input, the stall changes only at the falling edge.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall <= (rst_n && !calm) ? ($urandom_range(99) < IDLE_PCT) : 1'b0;
        end
    end

    // The watchdog ends the run when no item moves on either channel for too
    // long. Handshakes are sampled at the rising edge, where they count.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("banked_compacting_list_engine regression: fail");
        $finish;
    end

    function automatic bcle_cmd_t make_cmd(logic [ACTION_W-1:0] action, int room,
                                           int layer, int id, int index);
        bcle_cmd_t c;
        c.action      = action;
        c.room        = ROOM_W'(room);
        c.layer       = LAYER_W'(layer);
        c.object_id   = ID_W'(id);
        c.entry_index = IDX_W'(index);
        return c;
    endfunction

    // Presents one command item and holds it until the engine takes it. The
    // task starts and ends at a falling edge, so cmd_valid gets a single
    // assignment per edge: back-to-back items keep it high throughout.
    task automatic send_cmd(bcle_cmd_t c);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            cmd       <= bcle_cmd_t'($bits(bcle_cmd_t)'($urandom));
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random command item. Most items address the focus lists and use a small
    // pool of ids so that removals hit; the rest spread over all rooms, use
    // full-width ids, or address rooms that do not exist.
    function automatic bcle_cmd_t pick_list_command(int focus_room, int focus_lo,
                                                    int focus_hi);
        bcle_cmd_t c;
        int        roll;
        c.object_id   = ($urandom_range(99) < 70) ? ID_W'($urandom_range(7))
                                                  : ID_W'($urandom);
        c.entry_index = ($urandom_range(99) < 60) ? IDX_W'($urandom_range(7))
                                                  : IDX_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 82)
            c.room = ROOM_W'(focus_room);
        else if (roll < 96)
            c.room = ROOM_W'($urandom_range(ROOMS - 1));
        else
            c.room = ROOM_W'($urandom_range((1 << ROOM_W) - 1, ROOMS));
        roll = $urandom_range(99);
        if (roll < 35)
            c.layer = LAYER_W'(focus_lo);
        else if (roll < 70)
            c.layer = LAYER_W'(focus_hi);
        else
            c.layer = LAYER_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 42)
            c.action = ACT_APPEND;
        else if (roll < 64)
            c.action = ACT_REMOVE;
        else if (roll < 72)
            c.action = ACT_REMOVE_ALL;
        else if (roll < 74)
            c.action = ACT_CLEAR;
        else if (roll < 97)
            c.action = ACT_READ;
        else
            c.action = ACTION_W'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
        return c;
    endfunction

    initial
    begin
        bcle_cmd_t c;
        int        applied;
        int        focus_room;
        int        focus_lo;
        int        focus_hi;

        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        calm      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening. Empty lists first: a read and a removal have
        // nothing to find.
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_REMOVE, 0, 0, 1023, 0));

        // Fill the last list of the last room with ids that toggle every bit,
        // the lowest first and the highest last, then append once more to a
        // full list, which must leave it unchanged.
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (k == 0)
                send_cmd(make_cmd(ACT_APPEND, ROOMS - 1, LAYERS - 1, 0, 0));
            else if (k == CAPACITY - 1)
                send_cmd(make_cmd(ACT_APPEND, ROOMS - 1, LAYERS - 1, 1023, 0));
            else
                send_cmd(make_cmd(ACT_APPEND, ROOMS - 1, LAYERS - 1,
                                  ((k % 2) ? 'h2AA : 'h155) ^ k, 0));
        end
        send_cmd(make_cmd(ACT_APPEND, ROOMS - 1, LAYERS - 1, 5, 0));
        send_cmd(make_cmd(ACT_READ, ROOMS - 1, LAYERS - 1, 0, 15));

        // A removal from the middle shifts the tail left; the last id then
        // sits one place lower.
        send_cmd(make_cmd(ACT_REMOVE, ROOMS - 1, LAYERS - 1, 'h2AA ^ 1, 0));
        send_cmd(make_cmd(ACT_READ, ROOMS - 1, LAYERS - 1, 0, 14));

        // Removal over all layers finds the id only in layer 7. Clearing the
        // room then leaves layers 6 and 7 alone.
        send_cmd(make_cmd(ACT_REMOVE_ALL, ROOMS - 1, LAYERS - 1, 0, 0));
        send_cmd(make_cmd(ACT_CLEAR, ROOMS - 1, LAYERS - 1, 0, 0));

        // A room that does not exist, and an action code that is not defined.
        send_cmd(make_cmd(ACT_APPEND, (1 << ROOM_W) - 1, 0, 1, 0));
        send_cmd(make_cmd(ACT_UNUSED_LAST, 0, 3, 1023, 15));

        // Random part.
        applied    = 0;
        focus_room = 0;
        focus_lo   = 0;
        focus_hi   = 0;
        while (applied < RANDOM_ITEMS)
        begin
            if (applied % FOCUS_SPAN == 0)
            begin
                focus_room = $urandom_range(ROOMS - 1);
                focus_lo   = $urandom_range(CLEARED_LAYERS - 1);
                focus_hi   = $urandom_range(LAYERS - 1, CLEARED_LAYERS);
            end
            calm = (applied >= CALM_FIRST && applied < CALM_LAST);
            c = pick_list_command(focus_room, focus_lo, focus_hi);
            send_cmd(c);
            if (int'(c.room) < ROOMS && c.action <= ACT_READ)
                applied++;
        end
        calm      = 1'b0;
        cmd_valid <= 1'b0;

        // Wait for every owed result, then give the engine time to show any
        // result it should not produce.
        wait (results_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("banked_compacting_list_engine regression: pass");
        else
            $display("banked_compacting_list_engine regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bcle_pkg.sv
hw/rtl/banked_compacting_list_engine.sv
dv/banked_compacting_list_engine_checker.sv
dv/banked_compacting_list_engine_tb.sv
